[rtl/core/wrws_pkg.sv]
// Shared package of the weighted random walk step block.
// Holds payload structs, opcodes, status codes and the arithmetic unit control types.
// No dependencies.
package wrws_pkg;

  // Default sizing, handed to the top level parameters
  localparam int WRWS_MAX_NODES     = 64;
  localparam int WRWS_WEIGHT_BITS   = 16;
  localparam int WRWS_FRACTION_BITS = 16;

  // Configuration register indexes and reset values
  localparam logic [0:0]  REG_NODE_COUNT    = 1'b0;
  localparam logic [0:0]  REG_PATH_LENGTH   = 1'b1;
  localparam logic [6:0]  NODE_COUNT_RESET  = 7'd64;
  localparam logic [15:0] PATH_LENGTH_RESET = 16'd40;

  // Request operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_NODE     = 2'd0;
  localparam logic [1:0] STATUS_DEAD     = 2'd1;
  localparam logic [1:0] STATUS_FINISHED = 2'd2;

  // One request transaction
  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  row_node;
    logic [5:0]  column_node;
    logic [15:0] edge_weight;
    logic [15:0] random_fraction;
  } request_t;

  // One result transaction
  typedef struct packed {
    logic [5:0]  next_node;
    logic [15:0] position;
    logic [1:0]  status;
    logic        walk_done;
  } result_t;

  // Shared arithmetic unit operations
  typedef enum logic [2:0] {
    ALU_HOLD,
    ALU_CLR,
    ALU_ADD,
    ALU_LATCH,
    ALU_MAC,
    ALU_THR
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    mul_bit;
  } alu_ctrl_t;

  typedef struct packed {
    logic acc_zero;
    logic hit;
  } alu_stat_t;

endpackage

[rtl/core/wrws_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module wrws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/wrws_alu.sv]
// Shared accumulate unit: row sum, shift-add scaling of the fraction,
// rounded-up threshold and running-sum compare. Depends on wrws_pkg.
module wrws_alu import wrws_pkg::*; #(
  parameter int OPERAND_W     = 16,
  parameter int SUM_W         = 23,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  alu_ctrl_t            ctrl,
  input  logic [OPERAND_W-1:0] operand,
  output alu_stat_t            stat
);

  localparam int PROD_W = FRACTION_BITS + SUM_W;

  logic [PROD_W-1:0] acc;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  thr;
  logic [PROD_W-1:0] base;
  logic [PROD_W-1:0] addend;
  logic [PROD_W-1:0] total;
  logic [SUM_W-1:0]  ceil_q;

  // Single shared adder; MAC shifts the accumulator first
  always_comb begin
    addend = '0;
    case (ctrl.op)
      ALU_ADD: addend = PROD_W'(operand);
      ALU_MAC: addend = ctrl.mul_bit ? PROD_W'(sum) : '0;
      default: addend = '0;
    endcase
    base   = (ctrl.op == ALU_MAC) ? (acc << 1) : acc;
    total  = base + addend;
    // ceil(product / 2^FRACTION_BITS), never above the row sum
    ceil_q = acc[PROD_W-1:FRACTION_BITS] + SUM_W'(|acc[FRACTION_BITS-1:0]);
  end

  assign stat.hit      = (total >= PROD_W'(thr));
  assign stat.acc_zero = (acc == '0);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      ALU_CLR: acc <= '0;
      ALU_ADD: acc <= total;
      ALU_MAC: acc <= total;
      ALU_LATCH: begin
        sum <= acc[SUM_W-1:0];
        acc <= '0;
      end
      ALU_THR: begin
        thr <= ceil_q;
        acc <= '0;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/weighted_random_walk_step.sv]
// Weighted random walk step: a write transaction stores one edge weight in the RAM; a start
// transaction, or a step with no walk running, goes to the emit state and stalls the
// request side until its result is loaded into the output register; a step transaction
// makes two passes over the columns in use of the current row through the single read port
// of the weight RAM (row sum, then running-sum search), with the bit-per-cycle scaling of
// the random fraction in the shared accumulate unit between them; a zero row sum ends it.
// The request side stalls while a transaction is in progress; a finished result waits in an
// output register, and the next request is taken while it waits. Weights are unsigned 8.8
// fixed point and the RAM is not cleared: every entry of a row must be written before a walk
// reads it.
// Depends on wrws_pkg, wrws_ram and wrws_alu.
module weighted_random_walk_step import wrws_pkg::*; #(
  parameter int MAX_NODES     = WRWS_MAX_NODES,
  parameter int WEIGHT_BITS   = WRWS_WEIGHT_BITS,
  parameter int FRACTION_BITS = WRWS_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        request_valid,
  output logic        request_stall,
  input  request_t    request,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        write_enable,
  input  logic [0:0]  register_index,
  input  logic [15:0] write_data
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int NCNT_W = $clog2(MAX_NODES + 1);
  localparam int SUM_W  = WEIGHT_BITS + NCNT_W;
  localparam int ADDR_W = 2 * NODE_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int MCNT_W = $clog2(FRACTION_BITS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SUM  = 6'b000010,
    S_MUL  = 6'b000100,
    S_THR  = 6'b001000,
    S_SCAN = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [6:0]               node_count;
  logic [15:0]              path_length;
  logic [NODE_W-1:0]        walk_node;
  logic [15:0]              walk_position;
  logic                     walk_active;
  logic [NCNT_W-1:0]        col;
  logic [NODE_W-1:0]        rd_col;
  logic                     rd_pend;
  logic [FRACTION_BITS-1:0] frac;
  logic [MCNT_W-1:0]        mul_cnt;
  result_t                  pending;

  logic [NCNT_W-1:0]      n;
  logic [15:0]            plen;
  logic                   accept;
  logic                   out_free;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [WEIGHT_BITS-1:0] wr_data;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [NODE_W-1:0]      origin_node;
  logic                   start_done;
  logic [15:0]            pos_inc;
  logic                   step_done;
  logic                   sum_done;
  logic                   scan_end;
  alu_ctrl_t              alu_ctrl;
  alu_stat_t              alu_stat;

  // Effective node count and walk length
  always_comb begin
    if (node_count == '0) begin
      n = NCNT_W'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      n = NCNT_W'(MAX_NODES);
    end else begin
      n = NCNT_W'(node_count);
    end
    plen = (path_length == '0) ? 16'd1 : path_length;
  end

  assign request_stall = (state != S_IDLE);
  assign accept        = request_valid && !request_stall;
  assign out_free      = !result_valid || !result_stall;

  // Weight writes go straight to the RAM
  assign wr_en   = accept && (request.operation == OP_WRITE) &&
                   (32'(request.row_node) < MAX_NODES) &&
                   (32'(request.column_node) < MAX_NODES);
  assign wr_addr = {NODE_W'(request.row_node), NODE_W'(request.column_node)};
  assign wr_data = WEIGHT_BITS'(request.edge_weight);

  // Row reads, one column per cycle during both passes
  assign rd_en   = ((state == S_SUM) || (state == S_SCAN)) && (col < n);
  assign rd_addr = {walk_node, col[NODE_W-1:0]};

  assign origin_node = (32'(request.row_node) >= 32'(n)) ? NODE_W'(n - 1'b1)
                                                         : NODE_W'(request.row_node);
  assign start_done = (path_length <= 16'd1);
  assign pos_inc    = walk_position + 16'd1;
  assign step_done  = ({1'b0, pos_inc} + 17'd1) >= {1'b0, plen};
  assign sum_done   = (col == n) && !rd_pend;
  assign scan_end   = rd_pend && (alu_stat.hit || (rd_col == NODE_W'(n - 1'b1)));

  wrws_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_weights (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wrws_alu #(
    .OPERAND_W     (WEIGHT_BITS),
    .SUM_W         (SUM_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_alu (
    .clk     (clk),
    .ctrl    (alu_ctrl),
    .operand (rd_data),
    .stat    (alu_stat)
  );

  // Sequencer: next state and arithmetic unit control
  always_comb begin
    state_next       = state;
    alu_ctrl.op      = ALU_HOLD;
    alu_ctrl.mul_bit = frac[FRACTION_BITS-1];
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.operation)
            OP_START: state_next = S_EMIT;
            OP_STEP: begin
              if (walk_active) begin
                state_next  = S_SUM;
                alu_ctrl.op = ALU_CLR;
              end else begin
                state_next = S_EMIT;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SUM: begin
        if (rd_pend) begin
          alu_ctrl.op = ALU_ADD;
        end else if (sum_done) begin
          if (alu_stat.acc_zero) begin
            state_next = S_EMIT;
          end else begin
            state_next  = S_MUL;
            alu_ctrl.op = ALU_LATCH;
          end
        end
      end
      S_MUL: begin
        alu_ctrl.op = ALU_MAC;
        if (mul_cnt == MCNT_W'(FRACTION_BITS - 1)) begin
          state_next = S_THR;
        end
      end
      S_THR: begin
        alu_ctrl.op = ALU_THR;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        if (rd_pend) begin
          alu_ctrl.op = ALU_ADD;
        end
        if (scan_end) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Walk state, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      node_count    <= NODE_COUNT_RESET;
      path_length   <= PATH_LENGTH_RESET;
      walk_node     <= '0;
      walk_position <= '0;
      walk_active   <= 1'b0;
      col           <= '0;
      rd_pend       <= 1'b0;
      mul_cnt       <= '0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // Configuration writes
      if (write_enable) begin
        case (register_index)
          REG_NODE_COUNT:  node_count  <= write_data[6:0];
          REG_PATH_LENGTH: path_length <= write_data;
          default: ;
        endcase
      end

      // Output register: load the pending result or hand the current one over
      if ((state == S_EMIT) && out_free) begin
        result       <= pending;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      // Read pipeline tracking
      rd_pend <= rd_en;
      if (rd_en) begin
        col    <= col + 1'b1;
        rd_col <= col[NODE_W-1:0];
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (request.operation)
              OP_START: begin
                walk_node         <= origin_node;
                walk_position     <= '0;
                walk_active       <= !start_done;
                pending.next_node <= 6'(origin_node);
                pending.position  <= '0;
                pending.status    <= STATUS_NODE;
                pending.walk_done <= start_done;
              end
              OP_STEP: begin
                if (walk_active) begin
                  col     <= '0;
                  frac    <= FRACTION_BITS'(request.random_fraction);
                  mul_cnt <= '0;
                end else begin
                  pending.next_node <= 6'(walk_node);
                  pending.position  <= walk_position;
                  pending.status    <= STATUS_FINISHED;
                  pending.walk_done <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_SUM: begin
          // Zero row sum ends the walk as a dead end
          if (sum_done && alu_stat.acc_zero) begin
            walk_active       <= 1'b0;
            pending.next_node <= 6'(walk_node);
            pending.position  <= pos_inc;
            pending.status    <= STATUS_DEAD;
            pending.walk_done <= 1'b1;
          end
        end
        S_MUL: begin
          frac    <= frac << 1;
          mul_cnt <= mul_cnt + 1'b1;
        end
        S_THR: begin
          col <= '0;
        end
        S_SCAN: begin
          // First column whose running sum reaches the threshold
          if (scan_end) begin
            walk_node     <= rd_col;
            walk_position <= pos_inc;
            if (step_done) begin
              walk_active <= 1'b0;
            end
            pending.next_node <= 6'(rd_col);
            pending.position  <= pos_inc;
            pending.status    <= STATUS_NODE;
            pending.walk_done <= step_done;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A new result only comes out of the emit state
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_EMIT))
    else $error("result raised outside emit state");

  // The walk stops only on the way to emitting its last result
  a_walk_stop: assert property (@(posedge clk) disable iff (rst)
    $fell(walk_active) |-> (state == S_EMIT))
    else $error("walk stopped without a result");

  // Scaling runs without interruption into the threshold cycle
  a_mul_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_MUL) || (state == S_THR))
    else $error("scaling sequence broken");

  // A free output register takes the pending result and returns to idle
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && out_free |=> (state == S_IDLE) && result_valid)
    else $error("pending result not delivered");
`endif

endmodule
